@@ rtl/brt_pkg.sv @@
// Shared types, codes and widths of the breakpoint table linearizer.
// Used by the controller, the datapath and the top level; no dependencies.
package brt_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int VAL_W          = 48;
    localparam int SLOPE_W        = 32;
    localparam int ENT_W          = 2 * VAL_W + SLOPE_W;
    localparam int SEG_W          = 6;
    localparam int CMD_W          = 2;
    localparam int CNT_W          = 7;
    localparam int SEL_W          = 4;
    localparam int IN_TDATA_W     = 184;
    localparam int OUT_TDATA_W    = 56;

    // Input commands.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_R2E  = 2'd1;
    localparam logic [1:0] CMD_E2R  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SEL = 1'b0;
    localparam logic CFG_CNT = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OOR    = 3'd1;
    localparam logic [2:0] ST_NOCONV = 3'd2;
    localparam logic [2:0] ST_ZERO   = 3'd3;
    localparam logic [2:0] ST_BAD    = 3'd4;

    // Path taken by an accepted item.
    localparam logic [1:0] K_LOAD   = 2'd0;
    localparam logic [1:0] K_NOCONV = 2'd1;
    localparam logic [1:0] K_BAD    = 2'd2;
    localparam logic [1:0] K_CONV   = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_ACCEPT  = 4'd1;
    localparam logic [3:0] OP_UP_RD   = 4'd2;
    localparam logic [3:0] OP_SEG_INC = 4'd3;
    localparam logic [3:0] OP_SEG_DEC = 4'd4;
    localparam logic [3:0] OP_SET_OOR = 4'd5;
    localparam logic [3:0] OP_PREP    = 4'd6;
    localparam logic [3:0] OP_MUL1    = 4'd7;
    localparam logic [3:0] OP_MUL2    = 4'd8;
    localparam logic [3:0] OP_DIV     = 4'd9;
    localparam logic [3:0] OP_TERM    = 4'd10;
    localparam logic [3:0] OP_FIN     = 4'd11;

    typedef struct packed {
        logic       in_ready;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] kind;
        logic       key_le;
        logic       up_top;
        logic       seg_zero;
        logic       slope_zero;
        logic       by_raw;
        logic       div_last;
        logic       out_free;
    } t_stat;

endpackage

@@ rtl/brt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/brt_ctrl.sv @@
// Controller state machine: sequences the segment walk, multiply, divide and output.
// Depends on brt_pkg for the command and status structs.
module brt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  brt_pkg::t_stat i_stat,
    output brt_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_DN_RD  = 4'd3;
    localparam logic [3:0] S_DN_CMP = 4'd4;
    localparam logic [3:0] S_PREP   = 4'd5;
    localparam logic [3:0] S_MUL1   = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_TERM   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = brt_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.op = brt_pkg::OP_ACCEPT;
                    n_state  = (i_stat.kind == brt_pkg::K_CONV) ? S_UP_RD : S_FIN;
                end
            end
            S_UP_RD: begin
                o_cmd.op = brt_pkg::OP_UP_RD;
                n_state  = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (i_stat.key_le) begin
                    o_cmd.op = brt_pkg::OP_SEG_INC;
                    n_state  = i_stat.up_top ? S_DN_RD : S_UP_RD;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.key_le) begin
                    n_state = S_PREP;
                end else if (i_stat.seg_zero) begin
                    o_cmd.op = brt_pkg::OP_SET_OOR;
                    n_state  = S_PREP;
                end else begin
                    o_cmd.op = brt_pkg::OP_SEG_DEC;
                    n_state  = S_DN_RD;
                end
            end
            S_PREP: begin
                o_cmd.op = brt_pkg::OP_PREP;
                if (i_stat.slope_zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = i_stat.by_raw ? S_MUL1 : S_DIV;
                end
            end
            S_MUL1: begin
                o_cmd.op = brt_pkg::OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = brt_pkg::OP_MUL2;
                n_state  = S_TERM;
            end
            S_DIV: begin
                o_cmd.op = brt_pkg::OP_DIV;
                if (i_stat.div_last) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                o_cmd.op = brt_pkg::OP_TERM;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = brt_pkg::OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/brt_dp.sv @@
// Datapath: configuration registers, breakpoint table, search position, multiply,
// restoring divider and output register. Depends on brt_pkg and brt_ram.
module brt_dp #(
    parameter int MAX_POINTS = brt_pkg::MAX_POINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  brt_pkg::t_cmd                    i_cmd,
    output brt_pkg::t_stat                   o_stat,
    input  logic                             i_s_tvalid,
    input  logic [brt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic [brt_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [brt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic [2:0]                       o_m_tuser,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_index,
    input  logic [brt_pkg::CNT_W-1:0]        i_cfg_data
);

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = (IW + 2 > 8) ? IW + 2 : 8;
    localparam int VW  = brt_pkg::VAL_W;
    localparam int SW  = brt_pkg::SLOPE_W;
    localparam int EW  = brt_pkg::ENT_W;
    localparam logic signed [VW+4:0] SAT_MAX = (VW+5)'({1'b0, {(VW-1){1'b1}}});
    localparam logic signed [VW+4:0] SAT_MIN = -SAT_MAX - (VW+5)'(1);
    localparam logic [64:0] TERM_LIM = 65'(1) << 50;

    // Input field unpacking.
    logic [1:0]           in_cmd;
    logic signed [VW-1:0] in_value;
    logic                 in_restart;
    logic [5:0]           in_idx;
    logic [EW-1:0]        in_entry;
    assign in_cmd     = i_s_tuser;
    assign in_value   = i_s_tdata[47:0];
    assign in_restart = i_s_tdata[48];
    assign in_idx     = i_s_tdata[54:49];
    assign in_entry   = i_s_tdata[182:55];

    logic [brt_pkg::SEL_W-1:0] r_sel;
    logic [brt_pkg::CNT_W-1:0] r_cnt;
    logic [IW-1:0]             r_pos;
    logic [IW-1:0]             r_seg;
    logic signed [VW-1:0]      r_x;
    logic                      r_by_raw;
    logic [1:0]                r_kind;
    logic                      r_oor;
    logic                      r_zero;
    logic signed [VW-1:0]      r_base;
    logic [48:0]               r_a;
    logic [SW-1:0]             r_b;
    logic                      r_neg;
    logic [63:0]               r_plo;
    logic [48:0]               r_phi;
    logic [63:0]               r_num;
    logic [SW-1:0]             r_rem;
    logic [63:0]               r_quo;
    logic [5:0]                r_dcnt;
    logic signed [51:0]        r_term;
    logic                      r_ovalid;
    logic signed [VW-1:0]      r_res;
    logic [2:0]                r_st;
    logic [5:0]                r_oseg;

    logic accept;
    assign accept = i_cmd.in_ready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            r_cnt <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                brt_pkg::CFG_SEL: r_sel <= i_cfg_data[brt_pkg::SEL_W-1:0];
                brt_pkg::CFG_CNT: r_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Path classification of the item at the input.
    logic [CW-1:0] n_pts;
    logic [1:0]    in_kind;
    assign n_pts = CW'(r_cnt);
    always_comb begin
        if (in_cmd == brt_pkg::CMD_LOAD) begin
            in_kind = brt_pkg::K_LOAD;
        end else if (!(in_cmd inside {brt_pkg::CMD_R2E, brt_pkg::CMD_E2R})
                     || r_sel < brt_pkg::SEL_W'(2)) begin
            in_kind = brt_pkg::K_NOCONV;
        end else if (n_pts < CW'(2) || n_pts > CW'(MAX_POINTS)) begin
            in_kind = brt_pkg::K_BAD;
        end else begin
            in_kind = brt_pkg::K_CONV;
        end
    end

    // Table write on a load transaction; slots past the table are dropped.
    logic [15:0]   idx_w;
    logic          ram_we;
    logic [IW-1:0] ram_ra;
    logic [EW-1:0] ram_q;
    assign idx_w  = 16'(in_idx);
    assign ram_we = accept && (in_kind == brt_pkg::K_LOAD) && (idx_w < 16'(MAX_POINTS));
    assign ram_ra = (i_cmd.op == brt_pkg::OP_UP_RD) ? r_seg + IW'(1) : r_seg;

    brt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_w[IW-1:0]),
        .i_wdata (in_entry),
        .i_raddr (ram_ra),
        .o_rdata (ram_q)
    );

    logic signed [VW-1:0] q_raw, q_eng, q_key;
    logic signed [SW-1:0] q_slope;
    assign q_raw   = ram_q[VW-1:0];
    assign q_eng   = ram_q[2*VW-1:VW];
    assign q_slope = ram_q[EW-1:2*VW];
    assign q_key   = r_by_raw ? q_raw : q_eng;

    // Start segment: cached position, or zero on a restart, pulled back below the last point.
    logic [CW-1:0] start_p, start_seg;
    always_comb begin
        start_p   = in_restart ? '0 : CW'(r_pos);
        start_seg = (start_p + CW'(1) >= n_pts) ? n_pts - CW'(2) : start_p;
    end

    // Operands of the interpolation step.
    logic signed [VW:0] prep_d;
    logic [48:0]        prep_a;
    logic [SW-1:0]      prep_b;
    assign prep_d = (VW+1)'(r_x) - (VW+1)'(q_key);
    assign prep_a = prep_d[VW] ? 49'(-prep_d) : 49'(prep_d);
    assign prep_b = q_slope[SW-1] ? SW'(-q_slope) : SW'(q_slope);

    // One restoring division step.
    logic [SW:0] div_rem2;
    logic        div_ge;
    assign div_rem2 = {r_rem, r_num[63]};
    assign div_ge   = div_rem2 >= (SW+1)'(r_b);

    // Magnitude of the product or quotient, clamped.
    logic [64:0] term_m, term_c;
    always_comb begin
        if (r_by_raw) begin
            term_m = {r_phi, 16'h0} + 65'(r_plo[63:16]);
        end else begin
            term_m = 65'(r_quo);
        end
        term_c = (term_m > TERM_LIM) ? TERM_LIM : term_m;
    end

    logic signed [VW+4:0] fin_sum, fin_sat;
    always_comb begin
        fin_sum = (VW+5)'(r_base) + (VW+5)'(r_term);
        if (fin_sum > SAT_MAX) begin
            fin_sat = SAT_MAX;
        end else if (fin_sum < SAT_MIN) begin
            fin_sat = SAT_MIN;
        end else begin
            fin_sat = fin_sum;
        end
    end

    logic [15:0] seg_w;
    assign seg_w = 16'(r_seg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (accept && in_kind == brt_pkg::K_CONV && in_restart) begin
                r_pos <= '0;
            end
            if (i_cmd.op == brt_pkg::OP_FIN) begin
                r_ovalid <= 1'b1;
                if (r_kind == brt_pkg::K_CONV && !r_zero) begin
                    r_pos <= r_seg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            brt_pkg::OP_ACCEPT: begin
                if (accept) begin
                    r_x      <= in_value;
                    r_by_raw <= (in_cmd == brt_pkg::CMD_R2E);
                    r_kind   <= in_kind;
                    r_oor    <= 1'b0;
                    r_zero   <= 1'b0;
                    r_seg    <= start_seg[IW-1:0];
                end
            end
            brt_pkg::OP_SEG_INC: begin
                r_seg <= r_seg + IW'(1);
                if (o_stat.up_top) begin
                    r_oor <= 1'b1;
                end
            end
            brt_pkg::OP_SEG_DEC: begin
                r_seg <= r_seg - IW'(1);
            end
            brt_pkg::OP_SET_OOR: begin
                r_oor <= 1'b1;
            end
            brt_pkg::OP_PREP: begin
                r_base <= r_by_raw ? q_eng : q_raw;
                r_a    <= prep_a;
                r_b    <= prep_b;
                r_neg  <= prep_d[VW] ^ q_slope[SW-1];
                r_zero <= o_stat.slope_zero;
                r_num  <= {prep_a[47:0], 16'h0};
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= '0;
            end
            brt_pkg::OP_MUL1: begin
                r_plo <= r_a[31:0] * r_b;
            end
            brt_pkg::OP_MUL2: begin
                r_phi <= 49'(r_a[48:32]) * 49'(r_b);
            end
            brt_pkg::OP_DIV: begin
                r_rem  <= div_ge ? SW'(div_rem2 - (SW+1)'(r_b)) : div_rem2[SW-1:0];
                r_quo  <= {r_quo[62:0], div_ge};
                r_num  <= {r_num[62:0], 1'b0};
                r_dcnt <= r_dcnt + 6'd1;
            end
            brt_pkg::OP_TERM: begin
                r_term <= r_neg ? -52'(term_c) : 52'(term_c);
            end
            brt_pkg::OP_FIN: begin
                case (r_kind)
                    brt_pkg::K_LOAD: begin
                        r_res  <= '0;
                        r_st   <= brt_pkg::ST_OK;
                        r_oseg <= '0;
                    end
                    brt_pkg::K_NOCONV: begin
                        r_res  <= r_x;
                        r_st   <= brt_pkg::ST_NOCONV;
                        r_oseg <= '0;
                    end
                    brt_pkg::K_BAD: begin
                        r_res  <= r_x;
                        r_st   <= brt_pkg::ST_BAD;
                        r_oseg <= '0;
                    end
                    default: begin
                        r_oseg <= seg_w[5:0];
                        if (r_zero) begin
                            r_res <= r_x;
                            r_st  <= brt_pkg::ST_ZERO;
                        end else begin
                            r_res <= fin_sat[VW-1:0];
                            r_st  <= r_oor ? brt_pkg::ST_OOR : brt_pkg::ST_OK;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.in_valid   = i_s_tvalid;
        o_stat.kind       = in_kind;
        o_stat.key_le     = q_key <= r_x;
        o_stat.up_top     = CW'(r_seg) + CW'(1) >= n_pts - CW'(1);
        o_stat.seg_zero   = (r_seg == '0);
        o_stat.slope_zero = !r_by_raw && (q_slope == '0);
        o_stat.by_raw     = r_by_raw;
        o_stat.div_last   = (r_dcnt == 6'd63);
        o_stat.out_free   = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oseg, r_res};
    assign o_m_tuser  = r_st;

endmodule

@@ rtl/breakpoint_table_linearizer_unit.sv @@
// Top level of the breakpoint table linearizer: stream ports, configuration port,
// controller and datapath. Depends on brt_pkg, brt_ctrl and brt_dp.
//
// Converts signed Q31.16 values through a table of (raw, eng, slope) breakpoints,
// one item at a time, with exactly one result per item. A load or a rejected item
// goes from the accept straight to the output state. A conversion walks the table
// from the cached segment (or from zero on a restart), and every table compare takes
// a read through the registered read port, then the compare. Raw-to-eng then runs
// the split multiply and the clamp, and eng-to-raw runs the restoring divider, which
// produces one quotient bit per cycle over 64 bits; a zero slope in that direction
// skips the divider. The output register lets a result wait while the block is idle
// again. Configuration writes are taken in every cycle and should be made only
// while the block is idle.
module breakpoint_table_linearizer_unit #(
    parameter int MAX_POINTS = brt_pkg::MAX_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // value[47:0], restart_search[48], entry_index[54:49], entry_raw[102:55],
    // entry_eng[150:103], entry_slope[182:151], zero pad[183]
    input  logic [brt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // command[1:0]
    input  logic [brt_pkg::CMD_W-1:0]       i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // result_value[47:0], segment[53:48], zero pad[55:54]
    output logic [brt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]                      o_m_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [brt_pkg::CNT_W-1:0]       i_cfg_data
);

    brt_pkg::t_cmd  cmd;
    brt_pkg::t_stat stat;

    brt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    brt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_s_tready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

endmodule
